@@ hw/rtl/line_follow_pid_steering_top_macros.svh @@
`ifndef LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LFPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfps: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define LFPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfps: next-cycle check failed");

`endif

@@ hw/rtl/lfps_pkg.sv @@
package lfps_pkg;

   localparam int SENSOR_N    = 7;
   localparam int IN_W        = 7;
   localparam int SPEED_W     = 7;
   localparam int GAIN_W      = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 9;   // |sum| <= 224
   localparam int MAG_W       = 8;
   localparam int CNT_W       = 3;
   localparam int ERR_W       = 17;  // |err| <= 51200
   localparam int QUO_W       = 16;
   localparam int DERIV_W     = 18;
   localparam int INTEG_W     = 32;
   localparam int OPA_W       = 32;
   localparam int OPB_W       = 17;
   localparam int PROD_W      = OPA_W + OPB_W;
   localparam int ACC_W       = 50;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 19;  // 16-bit dividend + 3 bits for divisor <= 6
   localparam int FRAC_W      = 16;

   localparam logic [CNT_W-1:0]   CNT_NONE  = '0;
   localparam logic [CNT_W-1:0]   CNT_ALL   = CNT_W'(SENSOR_N);
   localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRUISE_PCT = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_INT,
      ST_MP,
      ST_MI,
      ST_MD,
      ST_MW,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ctrl_stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [SPEED_W-1:0] cruise_pct;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:     16'd256,
      gain_i:     16'd0,
      gain_d:     16'd0,
      cruise_pct: 7'd50
   };

   // Sensor weight, leftmost sensor first.
   function automatic logic signed [SUM_W-1:0] sensor_weight(input logic [CNT_W-1:0] idx);
      logic signed [SUM_W-1:0] w;
      case (idx)
         3'd0:    w = 9'sd200;
         3'd1:    w = 9'sd16;
         3'd2:    w = 9'sd8;
         3'd3:    w = 9'sd0;
         3'd4:    w = -9'sd8;
         3'd5:    w = -9'sd16;
         3'd6:    w = -9'sd200;
         default: w = 9'sd0;
      endcase
      return w;
   endfunction

   // ceil(2^RECIP_SHIFT / d), exact floor division for 16-bit dividends.
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         3'd1:    r = 20'd524288;
         3'd2:    r = 20'd262144;
         3'd3:    r = 20'd174763;
         3'd4:    r = 20'd131072;
         3'd5:    r = 20'd104858;
         3'd6:    r = 20'd87382;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/lfps_ifs.sv @@
interface lfps_req_if import lfps_pkg::*;;
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] ir_levels;

   modport source (output valid, output ir_levels, input ready);
   modport sink   (input valid, input ir_levels, output ready);
endinterface

interface lfps_rsp_if import lfps_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] left_pct;
   logic [SPEED_W-1:0] right_pct;

   modport source (output valid, output left_pct, output right_pct, input ready);
   modport sink   (input valid, input left_pct, input right_pct, output ready);
endinterface

@@ hw/rtl/lfps_mac.sv @@
module lfps_mac import lfps_pkg::*; (
   input  logic                     clock,
   input  mac_cmd_type              cmd,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul_en) begin
         prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      end
      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = ACC_W'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

@@ hw/rtl/lfps_ctrl.sv @@
module lfps_ctrl import lfps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   lfps_req_if.sink                  req,
   input  cfg_type                   cfg,
   input  logic                      out_free,
   input  logic signed [PROD_W-1:0]  prod,
   input  logic signed [ACC_W-1:0]   acc,
   output mac_cmd_type               cmd,
   output logic signed [OPA_W-1:0]   op_a,
   output logic signed [OPB_W-1:0]   op_b,
   output ctrl_stat_type             stat,
   output logic [SPEED_W-1:0]        left_pct,
   output logic [SPEED_W-1:0]        right_pct
);

   ctrl_state_type state_ff, state_in;

   logic signed [SUM_W-1:0]   sum_ff,   sum_in;
   logic [CNT_W-1:0]          cnt_ff,   cnt_in;
   logic signed [ERR_W-1:0]   err_ff,   err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   last_ff,  last_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;

   logic signed [SUM_W-1:0]   sen_sum;
   logic [CNT_W-1:0]          sen_cnt;
   logic signed [SUM_W-1:0]   sum_abs;
   logic [QUO_W-1:0]          quo;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [ACC_W:0]     base_q;
   logic signed [ACC_W:0]     acc_x;

   // Clamp a Q.16 wheel value to 0..SPEED_MAX; negatives truncate to zero.
   function automatic logic [SPEED_W-1:0] wheel(input logic signed [ACC_W:0] x);
      logic [SPEED_W-1:0] s;
      if (x < 0) begin
         s = '0;
      end else if (x[ACC_W:FRAC_W] > (ACC_W + 1 - FRAC_W)'(SPEED_MAX)) begin
         s = SPEED_MAX;
      end else begin
         s = x[FRAC_W +: SPEED_W];
      end
      return s;
   endfunction

   // Active-low sensors: weighted sum and count.
   always_comb begin
      sen_sum = '0;
      sen_cnt = '0;
      for (int i = 0; i < SENSOR_N; i++) begin
         if (!req.ir_levels[i]) begin
            sen_sum = sen_sum + sensor_weight(CNT_W'(i));
            sen_cnt = sen_cnt + 1'b1;
         end
      end
   end

   assign sum_abs   = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign quo       = prod[RECIP_SHIFT +: QUO_W];
   assign integ_sum = (INTEG_W + 1)'(integ_ff) + (INTEG_W + 1)'(err_ff);

   assign base_q    = $signed((ACC_W + 1)'({cfg.cruise_pct, {FRAC_W{1'b0}}}));
   assign acc_x     = (ACC_W + 1)'(acc);
   assign left_pct  = wheel(base_q + acc_x);
   assign right_pct = wheel(base_q - acc_x);

   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      integ_in  = integ_ff;
      last_in   = last_ff;
      deriv_in  = deriv_ff;
      cmd       = '0;
      op_a      = '0;
      op_b      = '0;
      stat      = '0;
      stat.busy = (state_ff != ST_IDLE);
      req.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid && sen_cnt != CNT_NONE && sen_cnt != CNT_ALL) begin
               sum_in   = sen_sum;
               cnt_in   = sen_cnt;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // |sum| * 256 / count by reciprocal multiply
            cmd.mul_en = 1'b1;
            op_a       = $signed(OPA_W'(recip(cnt_ff)));
            op_b       = $signed({1'b0, sum_abs[MAG_W-1:0], 8'd0});
            state_in   = ST_ERR;
         end
         ST_ERR: begin
            err_in   = sum_ff[SUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
            state_in = ST_INT;
         end
         ST_INT: begin
            if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
               integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                             : {1'b0, {(INTEG_W-1){1'b1}}};
            end else begin
               integ_in = integ_sum[INTEG_W-1:0];
            end
            deriv_in = DERIV_W'(err_ff) - DERIV_W'(last_ff);
            last_in  = err_ff;
            state_in = ST_MP;
         end
         ST_MP: begin
            cmd.mul_en = 1'b1;
            op_a       = OPA_W'(err_ff);
            op_b       = $signed({1'b0, cfg.gain_p});
            state_in   = ST_MI;
         end
         ST_MI: begin
            cmd.mul_en   = 1'b1;
            cmd.acc_load = 1'b1;
            op_a         = integ_ff;
            op_b         = $signed({1'b0, cfg.gain_i});
            state_in     = ST_MD;
         end
         ST_MD: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = 1'b1;
            op_a        = OPA_W'(deriv_ff);
            op_b        = $signed({1'b0, cfg.gain_d});
            state_in    = ST_MW;
         end
         ST_MW: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            stat.done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         integ_ff <= integ_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
   end

endmodule

@@ hw/rtl/line_follow_pid_steering_top.sv @@
// Line-follower PID steering.
// req carries one word per sensor sample (ir_levels, active low, bit 0 is
// the leftmost sensor). rsp carries one word of left_pct / right_pct,
// each 0..100. Both channels move a word when valid and ready are high.
// csr_we / csr_addr / csr_wdata write gain_p, gain_i, gain_d (unsigned Q8.8)
// and cruise_pct; write them only while the block is idle.
// A taken sample steps through DIV, ERR, INT, MP, MI, MD, MW and OUT; its
// word loads the output register as OUT is left, and no new sample is taken
// before the sequencer is back in idle, as the one shared multiplier is used
// in sequence for the position divide and the P, I and D products.
// A sample with no sensor or all sensors on the line is taken and dropped
// while idle; it gives no word and leaves the integral and last error.
// Reset (synchronous, active high) clears the integral and last error and
// loads the register defaults (gain_p 1.0, others 0, cruise_pct 50).
// A stalled receiver holds the word in the output register; a finished
// result then waits in the sequencer and req.ready stays low until it moves.
`include "line_follow_pid_steering_top_macros.svh"

module line_follow_pid_steering_top import lfps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lfps_req_if.sink              req,
   lfps_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0] left_ff,  left_in;
   logic [SPEED_W-1:0] right_ff, right_in;

   mac_cmd_type              cmd;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   ctrl_stat_type            stat;
   logic [SPEED_W-1:0]       left_pct;
   logic [SPEED_W-1:0]       right_pct;
   logic                     out_free;
   logic                     out_load;

   // register file, indexes outside the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_P:     cfg_in.gain_p     = csr_wdata;
            CSR_GAIN_I:     cfg_in.gain_i     = csr_wdata;
            CSR_GAIN_D:     cfg_in.gain_d     = csr_wdata;
            CSR_CRUISE_PCT: cfg_in.cruise_pct = csr_wdata[SPEED_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .prod      (prod),
      .acc       (acc),
      .cmd       (cmd),
      .op_a      (op_a),
      .op_b      (op_b),
      .stat      (stat),
      .left_pct  (left_pct),
      .right_pct (right_pct)
   );

   lfps_mac u_mac (
      .clock (clock),
      .cmd   (cmd),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign out_load = stat.done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         left_in      = left_pct;
         right_in     = right_pct;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_pct  = left_ff;
   assign rsp.right_pct = right_ff;

   // speeds stay inside the clamp
   `LFPS_ASSERT_SAME(a_speed_range, rsp.valid,
                     rsp.left_pct <= SPEED_MAX && rsp.right_pct <= SPEED_MAX)
   // a new word only comes from a finished sequence
   `LFPS_ASSERT_SAME(a_word_from_done, $rose(rsp.valid), $past(stat.done))
   // no sample is taken while a result is pending
   `LFPS_ASSERT_SAME(a_no_take_when_done, stat.done, !req.ready)
   // after a word loads, the sequencer is back to idle
   `LFPS_ASSERT_NEXT(a_idle_after_load, out_load, !stat.busy)

endmodule

@@ tb/sv/lfps_steering_checker.sv @@
module lfps_steering_checker import lfps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lfps_req_if                   req,
   lfps_rsp_if                   rsp,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    words_pending
);

   localparam int     MAX_REPORTS = 10;
   localparam longint INTEG_MAX   = 64'sd2147483647;
   localparam longint INTEG_MIN   = -64'sd2147483648;
   localparam int     SENSOR_WEIGHT [0:SENSOR_N-1] = '{200, 16, 8, 0, -8, -16, -200};

   typedef struct packed {
      logic [SPEED_W-1:0] left_pct;
      logic [SPEED_W-1:0] right_pct;
   } speed_word_type;

   cfg_type        steer_cfg;
   int             error_sum;
   int             prev_error;
   int             n_fail;
   speed_word_type expected_words[$];

   initial begin
      n_fail = 0;
   end

   // Q.16 wheel command -> percent, truncated toward zero, clamped.
   function automatic logic [SPEED_W-1:0] wheel_percent(input longint cmd_q16);
      longint pct;
      pct = cmd_q16 / 65536;
      if (pct < 0) pct = 0;
      if (pct > longint'(SPEED_MAX)) pct = longint'(SPEED_MAX);
      return SPEED_W'(pct);
   endfunction

   // Steering update for one sample; returns 0 when no word is due.
   function automatic bit steer_from_sample(input logic [IN_W-1:0] levels,
                                            output speed_word_type result);
      int     pos_sum;
      int     n_on;
      longint err;
      longint integ;
      longint deriv;
      longint corr;
      longint base_q16;
      pos_sum = 0;
      n_on    = 0;
      result  = '0;
      for (int k = 0; k < SENSOR_N; k++) begin
         if (!levels[k]) begin
            pos_sum += SENSOR_WEIGHT[k];
            n_on++;
         end
      end
      if (n_on == 0 || n_on == SENSOR_N) return 1'b0;

      err   = longint'(pos_sum * 256) / n_on;
      integ = longint'(error_sum) + err;
      if (integ > INTEG_MAX) integ = INTEG_MAX;
      if (integ < INTEG_MIN) integ = INTEG_MIN;
      error_sum = int'(integ);

      deriv = err - longint'(prev_error);
      corr  = longint'(steer_cfg.gain_p) * err
            + longint'(steer_cfg.gain_i) * integ
            + longint'(steer_cfg.gain_d) * deriv;
      prev_error = int'(err);

      base_q16         = longint'(steer_cfg.cruise_pct) * 65536;
      result.left_pct  = wheel_percent(base_q16 + corr);
      result.right_pct = wheel_percent(base_q16 - corr);
      return 1'b1;
   endfunction

   task automatic flag_field(input string what, input int want, input int got);
      n_fail++;
      if (n_fail <= MAX_REPORTS)
         $display("%s mismatch: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      speed_word_type seen;
      speed_word_type want;
      if (reset) begin
         steer_cfg  = CFG_RESET;
         error_sum  = 0;
         prev_error = 0;
         expected_words.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen.left_pct  = rsp.left_pct;
            seen.right_pct = rsp.right_pct;
            if (expected_words.size() == 0) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $display("unexpected word: left %0d right %0d",
                           seen.left_pct, seen.right_pct);
            end else begin
               want = expected_words.pop_front();
               if (want.left_pct !== seen.left_pct)
                  flag_field("left_pct", want.left_pct, seen.left_pct);
               if (want.right_pct !== seen.right_pct)
                  flag_field("right_pct", want.right_pct, seen.right_pct);
            end
         end
         if (req.valid && req.ready && steer_from_sample(req.ir_levels, want))
            expected_words.push_back(want);
         if (csr_we) begin
            case (csr_addr)
               CSR_GAIN_P:     steer_cfg.gain_p     = csr_wdata;
               CSR_GAIN_I:     steer_cfg.gain_i     = csr_wdata;
               CSR_GAIN_D:     steer_cfg.gain_d     = csr_wdata;
               CSR_CRUISE_PCT: steer_cfg.cruise_pct = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count    <= n_fail;
      words_pending <= expected_words.size();
   end

endmodule

@@ tb/sv/line_follow_pid_steering_top_tb.sv @@
module line_follow_pid_steering_top_tb;
   import lfps_pkg::*;

   localparam int N_SWEEP         = 18;    // directed samples at reset gains
   localparam int N_PHASES        = 6;
   localparam int WORDS_PER_PHASE = 195;   // samples that yield a word
   localparam int DRAIN_CYCLES    = 12;    // longer than the block's latency
   localparam int WATCHDOG_LIMIT  = 1000;

   // Directed sweep, p = 1.0 / base 50:
   //   no sensor and all sensors (dropped), each single sensor,
   //   left and right runs (non-integer positions, truncation both signs),
   //   six on each side, and balanced patterns that sum to zero.
   localparam logic [IN_W-1:0] SWEEP_SAMPLES [0:N_SWEEP-1] = '{
      7'h7F, 7'h00,
      7'h7E, 7'h7D, 7'h7B, 7'h77, 7'h6F, 7'h5F, 7'h3F,
      7'h7C, 7'h78, 7'h0F, 7'h70, 7'h60, 7'h40, 7'h01,
      7'h6B, 7'h55
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = CSR_GAIN_P;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int words_pending;
   int quiet_cycles = 0;
   bit calm = 1'b0;   // when set, both sides run with no gaps

   lfps_req_if req_ch ();
   lfps_rsp_if rsp_ch ();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_follow_pid_steering_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   lfps_steering_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // Watchdog: any word moving on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Offer one sample and hold it until taken. valid is only dropped when
   // a gap is drawn, so a back-to-back word never sees a low/high pair
   // in the same step.
   task automatic send_sample(input logic [IN_W-1:0] levels);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.ir_levels <= levels;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Park the request side and let every expected word come back; the
   // extra cycles cover a dropped sample still in flight.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; we drops once at the end.
   task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [SPEED_W-1:0] base);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_GAIN_P;
      csr_wdata <= kp;
      @(posedge clock);
      csr_addr  <= CSR_GAIN_I;
      csr_wdata <= ki;
      @(posedge clock);
      csr_addr  <= CSR_GAIN_D;
      csr_wdata <= kd;
      @(posedge clock);
      csr_addr  <= CSR_CRUISE_PCT;
      csr_wdata <= CSR_DATA_W'(base);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly a contiguous run of sensors on the line (what a real track
   // gives), with some raw noise and some empty/full samples mixed in.
   function automatic logic [IN_W-1:0] pick_sample();
      logic [IN_W-1:0] on_mask;
      int              first;
      int              run;
      on_mask = '0;
      case ($urandom_range(0, 9))
         0: return IN_W'($urandom_range(0, 127));
         1: return $urandom_range(0, 1) ? 7'h7F : 7'h00;
         default: begin
            first = $urandom_range(0, SENSOR_N - 1);
            run   = $urandom_range(1, SENSOR_N - first);
            for (int k = first; k < first + run; k++) on_mask[k] = 1'b1;
            return ~on_mask;
         end
      endcase
   endfunction

   // Result side: stall a random number of cycles before each word.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int               words;
      logic [IN_W-1:0]  sample;
      int               n_on;
      req_ch.valid     <= 1'b0;
      req_ch.ir_levels <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sweep at the reset register values.
      for (int k = 0; k < N_SWEEP; k++) send_sample(SWEEP_SAMPLES[k]);

      // Integral and derivative terms on, including a hard left/right swing
      // so the derivative sees both signs.
      settle();
      write_gains(16'd256, 16'd64, 16'd512, 7'd50);
      send_sample(7'h7E);
      send_sample(7'h3F);
      send_sample(7'h7E);
      send_sample(7'h77);

      // Random phases: default gains, all zero, all ones (base above 100),
      // full base speed, then random settings.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         settle();
         case (phase)
            0:       write_gains(16'd256, 16'd0, 16'd0, 7'd50);
            1:       write_gains(16'd0, 16'd0, 16'd0, 7'd0);
            2:       write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
            3:       write_gains(16'd0, 16'd0, 16'd0, 7'd100);
            default: write_gains(GAIN_W'($urandom_range(0, 1023)),
                                 GAIN_W'($urandom_range(0, 3)),
                                 GAIN_W'($urandom_range(0, 767)),
                                 SPEED_W'($urandom_range(0, 127)));
         endcase
         calm  = 1'b0;
         words = 0;
         while (words < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 39) == 0) calm = ~calm;
            sample = pick_sample();
            n_on   = $countones(~sample);
            if (n_on != 0 && n_on != SENSOR_N) words++;
            send_sample(sample);
         end
      end

      // Wait out every expected word, then the block's latency.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_ifs.sv
hw/rtl/lfps_mac.sv
hw/rtl/lfps_ctrl.sv
hw/rtl/line_follow_pid_steering_top.sv
tb/sv/lfps_steering_checker.sv
tb/sv/line_follow_pid_steering_top_tb.sv
